[sv/ppma_pkg.sv]
// Shared types, character codes and helper functions for the P3 image parser.
// No dependencies; every other file refers to this package by scoped names.

package ppma_pkg;

    localparam int HEADER_BITS_DEF = 16;

    // Parser position within the file
    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_WIDTH  = 3'd1,
        PH_HEIGHT = 3'd2,
        PH_MAXVAL = 3'd3,
        PH_RED    = 3'd4,
        PH_GREEN  = 3'd5,
        PH_BLUE   = 3'd6
    } phase_t;

    // Progress of the "P3" match on the current token
    typedef enum logic [1:0] {
        MAG_NONE = 2'd0,
        MAG_P    = 2'd1,
        MAG_P3   = 2'd2,
        MAG_FAIL = 2'd3
    } magic_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_3     = 8'h33;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] max_value;
    } result_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHAR_0) && (b <= CHAR_9);
    endfunction

endpackage

[sv/ppma_parse_core.sv]
// Parser state and the single-pass update for one byte: tokenising, magic match,
// number accumulation and result generation. Depends on ppma_pkg.

module ppma_parse_core #(
    parameter int HEADER_BITS = ppma_pkg::HEADER_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [7:0]          data_byte,
    input  logic                first_byte,
    output logic                res_valid,
    output ppma_pkg::result_t   res
);

    localparam int HB = HEADER_BITS;
    localparam int PW = HEADER_BITS + 4;

    ppma_pkg::phase_t phase_reg,  phase_next,  cur_phase;
    ppma_pkg::magic_t magic_reg,  magic_next,  cur_magic;
    logic             tok_reg,    tok_next,    cur_tok;
    logic             cmt_reg,    cmt_next,    cur_cmt;
    logic             nodig_reg,  nodig_next,  cur_nodig;
    logic             ended_reg,  ended_next,  cur_ended;
    logic             halted_reg, halted_next, cur_halted;
    logic [HB-1:0]    acc_reg,    acc_next,    cur_acc;
    logic [HB-1:0]    width_reg,  width_next,  cur_width;
    logic [HB-1:0]    height_reg, height_next, cur_height;
    logic [HB-1:0]    maxval_reg, maxval_next, cur_maxval;
    logic [7:0]       red_reg,    red_next,    cur_red;
    logic [7:0]       green_reg,  green_next,  cur_green;

    logic             dig;
    logic [HB-1:0]    acc_base;
    logic [PW-1:0]    prod;
    logic [HB-1:0]    acc_upd;
    logic [15:0]      width_clip, height_clip, maxval_clip;
    ppma_pkg::kind_t  res_kind;
    logic [7:0]       res_red, res_green, res_blue;

    // A new file starts from the reset state, then parses this byte as usual
    always_comb
    begin
        cur_phase  = first_byte ? ppma_pkg::PH_MAGIC : phase_reg;
        cur_magic  = first_byte ? ppma_pkg::MAG_NONE : magic_reg;
        cur_tok    = first_byte ? 1'b0 : tok_reg;
        cur_cmt    = first_byte ? 1'b0 : cmt_reg;
        cur_nodig  = first_byte ? 1'b0 : nodig_reg;
        cur_ended  = first_byte ? 1'b0 : ended_reg;
        cur_halted = first_byte ? 1'b0 : halted_reg;
        cur_acc    = first_byte ? '0 : acc_reg;
        cur_width  = first_byte ? '0 : width_reg;
        cur_height = first_byte ? '0 : height_reg;
        cur_maxval = first_byte ? '0 : maxval_reg;
        cur_red    = first_byte ? 8'd0 : red_reg;
        cur_green  = first_byte ? 8'd0 : green_reg;
    end

    assign dig      = ppma_pkg::is_digit(data_byte);
    assign acc_base = cur_tok ? cur_acc : '0;
    assign prod     = (PW'(acc_base) << 3) + (PW'(acc_base) << 1) + PW'(data_byte[3:0]);

    // Header values saturate; samples wrap
    always_comb
    begin
        if (cur_phase inside {ppma_pkg::PH_WIDTH, ppma_pkg::PH_HEIGHT, ppma_pkg::PH_MAXVAL})
            acc_upd = (|prod[PW-1:HB]) ? '1 : prod[HB-1:0];
        else
            acc_upd = prod[HB-1:0];
    end

    always_comb
    begin
        phase_next  = cur_phase;
        magic_next  = cur_magic;
        tok_next    = cur_tok;
        cmt_next    = cur_cmt;
        nodig_next  = cur_nodig;
        ended_next  = cur_ended;
        halted_next = cur_halted;
        acc_next    = cur_acc;
        width_next  = cur_width;
        height_next = cur_height;
        maxval_next = cur_maxval;
        red_next    = cur_red;
        green_next  = cur_green;
        res_valid   = 1'b0;
        res_kind    = ppma_pkg::KIND_HEADER;
        res_red     = 8'd0;
        res_green   = 8'd0;
        res_blue    = 8'd0;

        if (!cur_halted)
        begin
            if (cur_cmt)
            begin
                if (data_byte == ppma_pkg::CHAR_LF)
                    cmt_next = 1'b0;
            end
            else if (ppma_pkg::is_space(data_byte))
            begin
                if (cur_tok)
                begin
                    tok_next = 1'b0;
                    if (cur_phase == ppma_pkg::PH_MAGIC)
                    begin
                        if (cur_magic == ppma_pkg::MAG_P3)
                            phase_next = ppma_pkg::PH_WIDTH;
                    end
                    else if (cur_nodig)
                    begin
                        halted_next = 1'b1;
                        res_valid   = 1'b1;
                        res_kind    = ppma_pkg::KIND_ERROR;
                    end
                    else
                    begin
                        case (cur_phase)
                            ppma_pkg::PH_WIDTH:
                            begin
                                width_next = cur_acc;
                                phase_next = ppma_pkg::PH_HEIGHT;
                            end
                            ppma_pkg::PH_HEIGHT:
                            begin
                                height_next = cur_acc;
                                phase_next  = ppma_pkg::PH_MAXVAL;
                            end
                            ppma_pkg::PH_MAXVAL:
                            begin
                                maxval_next = cur_acc;
                                phase_next  = ppma_pkg::PH_RED;
                                res_valid   = 1'b1;
                                res_kind    = ppma_pkg::KIND_HEADER;
                            end
                            ppma_pkg::PH_RED:
                            begin
                                red_next   = cur_acc[7:0];
                                phase_next = ppma_pkg::PH_GREEN;
                            end
                            ppma_pkg::PH_GREEN:
                            begin
                                green_next = cur_acc[7:0];
                                phase_next = ppma_pkg::PH_BLUE;
                            end
                            ppma_pkg::PH_BLUE:
                            begin
                                phase_next = ppma_pkg::PH_RED;
                                res_valid  = 1'b1;
                                res_kind   = ppma_pkg::KIND_PIXEL;
                                res_red    = cur_red;
                                res_green  = cur_green;
                                res_blue   = cur_acc[7:0];
                            end
                            default:
                            begin
                                phase_next = cur_phase;
                            end
                        endcase
                    end
                end
            end
            else if (!cur_tok)
            begin
                if (data_byte == ppma_pkg::CHAR_HASH)
                    cmt_next = 1'b1;
                else
                begin
                    tok_next   = 1'b1;
                    magic_next = (data_byte == ppma_pkg::CHAR_P) ? ppma_pkg::MAG_P
                                                                 : ppma_pkg::MAG_FAIL;
                    nodig_next = !dig;
                    ended_next = 1'b0;
                    acc_next   = dig ? acc_upd : '0;
                end
            end
            else
            begin
                magic_next = (cur_magic == ppma_pkg::MAG_P && data_byte == ppma_pkg::CHAR_3)
                             ? ppma_pkg::MAG_P3 : ppma_pkg::MAG_FAIL;
                if (!cur_ended && !cur_nodig)
                begin
                    if (!dig)
                        ended_next = 1'b1;
                    else
                        acc_next = acc_upd;
                end
            end
        end
    end

    // Limit header values to 16 bits on output
    generate
        if (HB > 16)
        begin : g_clip
            assign width_clip  = (|width_next[HB-1:16])  ? 16'hFFFF : width_next[15:0];
            assign height_clip = (|height_next[HB-1:16]) ? 16'hFFFF : height_next[15:0];
            assign maxval_clip = (|maxval_next[HB-1:16]) ? 16'hFFFF : maxval_next[15:0];
        end
        else
        begin : g_ext
            assign width_clip  = 16'(width_next);
            assign height_clip = 16'(height_next);
            assign maxval_clip = 16'(maxval_next);
        end
    endgenerate

    assign res = {res_kind, res_red, res_green, res_blue,
                  width_clip, height_clip, maxval_clip};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ppma_pkg::PH_MAGIC;
            magic_reg  <= ppma_pkg::MAG_NONE;
            tok_reg    <= 1'b0;
            cmt_reg    <= 1'b0;
            nodig_reg  <= 1'b0;
            ended_reg  <= 1'b0;
            halted_reg <= 1'b0;
            acc_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            maxval_reg <= '0;
            red_reg    <= 8'd0;
            green_reg  <= 8'd0;
        end
        else if (go)
        begin
            phase_reg  <= phase_next;
            magic_reg  <= magic_next;
            tok_reg    <= tok_next;
            cmt_reg    <= cmt_next;
            nodig_reg  <= nodig_next;
            ended_reg  <= ended_next;
            halted_reg <= halted_next;
            acc_reg    <= acc_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            maxval_reg <= maxval_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
        end
    end

endmodule

[sv/ppma_result_reg.sv]
// Output register for parser results, with its valid/stall handshake.
// Depends on ppma_pkg for the result type.

module ppma_result_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic               res_valid,
    input  ppma_pkg::result_t  res,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_stall,
    output ppma_pkg::result_t  out_res
);

    logic              valid_reg, valid_next;
    ppma_pkg::result_t res_reg;

    // Free when empty or being drained this cycle
    assign can_load = !valid_reg || !out_stall;

    always_comb
    begin
        if (go && res_valid)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (go && res_valid)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

[sv/ppm_ascii_image_parser.sv]
// Plain-text P3 image parser: one byte per request, one result per header, pixel or error.
// Path: a byte is held in the input register, and its result in the output register.
// Throughput: one byte per cycle, with the combinational parse step between the
// input register and the output register; stalls only under output back-pressure.
// Reset: rst_n clears all parser state; a byte with first_byte set restarts the parse.
// Depends on ppma_pkg, ppma_parse_core and ppma_result_reg.

module ppm_ascii_image_parser #(
    parameter int HEADER_BITS = ppma_pkg::HEADER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [15:0] image_width,
    output logic [15:0] image_height,
    output logic [15:0] max_value
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        byte_reg;
    logic              first_reg;
    logic              can_load;
    logic              go;
    logic              accept;
    logic              res_valid;
    ppma_pkg::result_t res;
    ppma_pkg::result_t out_res;

    assign go       = in_valid_reg && can_load;
    assign in_stall = in_valid_reg && !go;
    assign accept   = in_valid && !in_stall;

    // Hold the byte until the parse step takes it
    assign in_valid_next = accept || (in_valid_reg && !go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= data_byte;
            first_reg <= first_byte;
        end
    end

    ppma_parse_core #(
        .HEADER_BITS (HEADER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .data_byte  (byte_reg),
        .first_byte (first_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    ppma_result_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .res_valid (res_valid),
        .res       (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind         = out_res.kind;
    assign red          = out_res.red;
    assign green        = out_res.green;
    assign blue         = out_res.blue;
    assign image_width  = out_res.image_width;
    assign image_height = out_res.image_height;
    assign max_value    = out_res.max_value;

endmodule
